[src/nis_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the nibble image stretch block.
// Used by every module under src; depends on nothing.
package nis_pkg;

  localparam int STORE_BYTES = 8192;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int FRAC_BITS   = 7;
  localparam int STEP_W      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef enum logic [2:0] {
    REG_SRC_W     = 3'd0,
    REG_SRC_H     = 3'd1,
    REG_DST_W     = 3'd2,
    REG_DST_H     = 3'd3,
    REG_REMAP_EN  = 3'd4,
    REG_REMAP_TBL = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]        src_w;
    logic [7:0]        src_h;
    logic [7:0]        dst_w;
    logic [7:0]        dst_h;
    logic              remap_en;
    logic [63:0]       remap_tbl;
    logic [STEP_W-1:0] hstep;
    logic [STEP_W-1:0] vstep;
  } cfg_t;

  typedef struct packed {
    logic                is_fetch;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
    logic [6:0]          row;
    logic [5:0]          col;
  } item_t;

endpackage

[src/nis_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: (src << 7) / den.
// Uses nis_pkg.
module nis_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [7:0]                src,
  input  logic [7:0]                den,
  output logic                      busy,
  output logic [nis_pkg::STEP_W-1:0] quo
);
  import nis_pkg::*;

  localparam int NUM_W = 8 + FRAC_BITS;

  logic [7:0]       rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [8:0]       shifted;
  logic [8:0]       diff;
  logic             fits;

  always_comb begin
    shifted  = {rem_r, quo_r[NUM_W-1]};
    fits     = shifted >= {1'b0, den};
    diff     = shifted - {1'b0, den};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = 8'd0;
      quo_nxt  = {src, {FRAC_BITS{1'b0}}};
      cnt_nxt  = 4'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[7:0] : shifted[7:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  // zero divisor gives a zero step
  assign quo  = (den == 8'd0) ? '0 : STEP_W'(quo_r);

endmodule

[src/nis_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers and the step computation for both axes.
// Uses nis_pkg and nis_div.
module nis_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  output nis_pkg::cfg_t cfg,
  output logic          busy
);
  import nis_pkg::*;

  logic [7:0]  src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic        remap_en_r;
  logic [63:0] remap_tbl_r;
  logic        start_r;
  logic        wr;
  logic        hbusy, vbusy;
  logic [STEP_W-1:0] hstep, vstep;

  assign cfg_ready = !busy;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= 8'd128;
      src_h_r     <= 8'd128;
      dst_w_r     <= 8'd128;
      dst_h_r     <= 8'd128;
      remap_en_r  <= 1'b0;
      remap_tbl_r <= 64'd0;
      start_r     <= 1'b1;
    end else begin
      // any write, even to an unused index, reruns the step division
      start_r <= wr;
      if (wr) begin
        case (reg_idx_t'(cfg_index))
          REG_SRC_W:     src_w_r     <= cfg_data[7:0];
          REG_SRC_H:     src_h_r     <= cfg_data[7:0];
          REG_DST_W:     dst_w_r     <= cfg_data[7:0];
          REG_DST_H:     dst_h_r     <= cfg_data[7:0];
          REG_REMAP_EN:  remap_en_r  <= cfg_data[0];
          REG_REMAP_TBL: remap_tbl_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  nis_div u_hdiv (
    .clk(clk), .rst_n(rst_n), .start(start_r), .src(src_w_r), .den(dst_w_r),
    .busy(hbusy), .quo(hstep)
  );

  nis_div u_vdiv (
    .clk(clk), .rst_n(rst_n), .start(start_r), .src(src_h_r), .den(dst_h_r),
    .busy(vbusy), .quo(vstep)
  );

  assign busy = start_r || hbusy || vbusy;

  always_comb begin
    cfg.src_w     = src_w_r;
    cfg.src_h     = src_h_r;
    cfg.dst_w     = dst_w_r;
    cfg.dst_h     = dst_h_r;
    cfg.remap_en  = remap_en_r;
    cfg.remap_tbl = remap_tbl_r;
    cfg.hstep     = hstep;
    cfg.vstep     = vstep;
  end

endmodule

[src/nis_front.sv]
`timescale 1ns / 1ps
// Front end: takes input beats, drops fetches outside the destination image.
// Uses nis_pkg.
module nis_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [12:0]                   in_load_address,
  input  logic [7:0]                    in_load_data,
  input  logic [6:0]                    in_dest_row,
  input  logic [5:0]                    in_dest_column,
  input  nis_pkg::cfg_t                 cfg,
  input  logic                          cfg_busy,
  input  logic                          q_full,
  output logic                          q_push,
  output nis_pkg::item_t                q_item
);
  import nis_pkg::*;

  logic [8:0] dst_half;
  logic       in_image;
  logic       keep;

  always_comb begin
    dst_half = ({1'b0, cfg.dst_w} + 9'd1) >> 1;
    in_image = ({1'b0, in_dest_row} < cfg.dst_h) && ({3'b0, in_dest_column} < dst_half);
    keep     = (in_mode == MODE_LOAD) || in_image;
    in_stall = q_full || cfg_busy;
    q_push   = in_valid && !in_stall && keep;
    q_item.is_fetch = (in_mode == MODE_FETCH);
    q_item.addr     = STORE_AW'(in_load_address);
    q_item.data     = in_load_data;
    q_item.row      = in_dest_row;
    q_item.col      = in_dest_column;
  end

endmodule

[src/nis_queue.sv]
`timescale 1ns / 1ps
// Short FIFO between the front end and the back end pipeline.
// Uses nis_pkg.
module nis_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nis_pkg::item_t push_item,
  input  logic           pop,
  output nis_pkg::item_t pop_item,
  output logic           full,
  output logic           valid
);
  import nis_pkg::*;

  item_t               slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  assign pop_item = slot_r[rd_ptr_r];
  assign full     = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);

endmodule

[src/nis_back.sv]
`timescale 1ns / 1ps
// Back end: address arithmetic, source store and nibble remap, one beat a cycle unless out_stall holds it.
// Uses nis_pkg.
module nis_back (
  input  logic           clk,
  input  logic           rst_n,
  input  nis_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  nis_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_pixel_pair,
  output logic [12:0]    out_dest_address
);
  import nis_pkg::*;

  logic en;

  // stage 1: products
  logic        v1_r;
  item_t       it1_r;
  logic [22:0] rowprod1_r;
  logic [21:0] colprod1_r;
  logic [14:0] dprod1_r;
  // stage 2: source row and the two horizontal positions
  logic        v2_r;
  item_t       it2_r;
  logic [15:0] srow2_r;
  logic [23:0] hpa2_r, hpb2_r;
  logic [12:0] daddr2_r;
  // stage 3: row base
  logic        v3_r;
  item_t       it3_r;
  logic [24:0] base3_r;
  logic [16:0] pa3_r, pb3_r;
  logic [12:0] daddr3_r;
  // stage 4: byte addresses
  logic                v4_r;
  item_t               it4_r;
  logic [STORE_AW-1:0] adra4_r, adrb4_r;
  logic                sela4_r, selb4_r;
  logic [12:0]         daddr4_r;
  // stage 5: store read
  logic        v5_r;
  logic [7:0]  rda5_r, rdb5_r;
  logic        sela5_r, selb5_r;
  logic [12:0] daddr5_r;
  // output register
  logic        out_valid_r;
  logic [7:0]  pair_r;
  logic [12:0] daddr_r;

  logic [7:0]  store [STORE_BYTES];

  logic [7:0]  dst_half;
  logic [8:0]  src_stride;
  logic [22:0] srow_sum;
  logic [24:0] idxa, idxb;
  logic [3:0]  nib_a, nib_b;

  function automatic logic [3:0] remap(input logic en_map, input logic [63:0] tbl,
                                       input logic [3:0] nib);
    logic [63:0] sh;
    sh = tbl >> {nib, 2'b00};
    return en_map ? sh[3:0] : nib;
  endfunction

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_valid;

  always_comb begin
    dst_half   = 8'(({1'b0, cfg.dst_w} + 9'd1) >> 1);
    src_stride = ({1'b0, cfg.src_w} + 9'd1) & 9'h1fe;
    srow_sum   = {8'd0, cfg.vstep[15:1]} + rowprod1_r;
    idxa       = base3_r + {8'd0, pa3_r};
    idxb       = base3_r + {8'd0, pb3_r};
    // even pixel index sits in the high nibble
    nib_a      = sela5_r ? rda5_r[3:0] : rda5_r[7:4];
    nib_b      = selb5_r ? rdb5_r[3:0] : rdb5_r[7:4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r && it4_r.is_fetch;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r      <= q_item;
      rowprod1_r <= q_item.row * cfg.vstep;
      colprod1_r <= q_item.col * cfg.hstep;
      dprod1_r   <= q_item.row * dst_half;

      it2_r    <= it1_r;
      srow2_r  <= srow_sum[22:FRAC_BITS];
      hpa2_r   <= {9'd0, cfg.hstep[15:1]} + {1'b0, colprod1_r, 1'b0};
      hpb2_r   <= {9'd0, cfg.hstep[15:1]} + {8'd0, cfg.hstep} + {1'b0, colprod1_r, 1'b0};
      daddr2_r <= 13'(dprod1_r + {9'd0, it1_r.col});

      it3_r    <= it2_r;
      base3_r  <= srow2_r * src_stride;
      pa3_r    <= hpa2_r[23:FRAC_BITS];
      pb3_r    <= hpb2_r[23:FRAC_BITS];
      daddr3_r <= daddr2_r;

      it4_r    <= it3_r;
      adra4_r  <= idxa[STORE_AW:1];
      adrb4_r  <= idxb[STORE_AW:1];
      sela4_r  <= idxa[0];
      selb4_r  <= idxb[0];
      daddr4_r <= daddr3_r;

      sela5_r  <= sela4_r;
      selb5_r  <= selb4_r;
      daddr5_r <= daddr4_r;

      pair_r  <= {remap(cfg.remap_en, cfg.remap_tbl, nib_a),
                  remap(cfg.remap_en, cfg.remap_tbl, nib_b)};
      daddr_r <= daddr5_r;
    end
  end

  // source store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (en) begin
      if (v4_r && !it4_r.is_fetch) store[it4_r.addr] <= it4_r.data;
      rda5_r <= store[adra4_r];
      rdb5_r <= store[adrb4_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_pair   = pair_r;
  assign out_dest_address = daddr_r;

endmodule

[src/nibble_image_stretch.sv]
`timescale 1ns / 1ps
// Nearest-neighbor scaler for packed 4-bit pixels, top level.
// Uses nis_pkg, nis_cfg, nis_front, nis_queue and nis_back.
//
// One beat is taken every cycle, loads and fetches alike, while the
// 4-entry queue has room, no step division runs and the back end is not
// held by out_stall. A fetch result passes the registers for products,
// positions, row base, byte address, store read, and nibble select and
// remap after the queue hands it on; loads and fetches outside the
// destination image give no beat. After reset and each configuration write
// the two step dividers run one quotient bit per cycle, with in_stall high.
// The source store is not cleared; every byte must be loaded before use.
module nibble_image_stretch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [12:0] in_load_address,
  input  logic [7:0]  in_load_data,
  input  logic [6:0]  in_dest_row,
  input  logic [5:0]  in_dest_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_pair,
  output logic [12:0] out_dest_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import nis_pkg::*;

  cfg_t  cfg;
  logic  cfg_busy;
  logic  q_push, q_pop, q_full, q_valid;
  item_t q_in, q_out;

  nis_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg), .busy(cfg_busy)
  );

  nis_front u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_load_address(in_load_address), .in_load_data(in_load_data),
    .in_dest_row(in_dest_row), .in_dest_column(in_dest_column),
    .cfg(cfg), .cfg_busy(cfg_busy), .q_full(q_full),
    .q_push(q_push), .q_item(q_in)
  );

  nis_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(q_in),
    .pop(q_pop), .pop_item(q_out), .full(q_full), .valid(q_valid)
  );

  nis_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_item(q_out),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_pair(out_pixel_pair), .out_dest_address(out_dest_address)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue pop while empty");

  a_step_rerun: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> cfg_busy) else $error("steps not recomputed");

endmodule

[sim/nibble_image_stretch_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for nibble_image_stretch: loads source images, fetches
// scaled bytes under random stalls and compares them with a local scaler model.
// Depends on nis_pkg and the RTL under src.
module nibble_image_stretch_tb;
  import nis_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [12:0] in_load_address;
  logic [7:0]  in_load_data;
  logic [6:0]  in_dest_row;
  logic [5:0]  in_dest_column;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_pixel_pair;
  logic [12:0] out_dest_address;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  nibble_image_stretch u_dut (.*);

  typedef struct packed {
    logic [7:0]  pair;
    logic [12:0] addr;
  } scaled_byte_t;

  // model state
  logic [7:0]  img_store [STORE_BYTES];
  logic [7:0]  m_sw, m_sh, m_dw, m_dh;
  logic        m_remap_en;
  logic [63:0] m_remap;
  logic [15:0] m_hstep, m_vstep;

  scaled_byte_t pending_bytes[$];
  int mismatches, fetch_beats, load_beats, checked;
  int idle_pct;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("FAIL nibble_image_stretch");
    $finish;
  end

  function automatic logic [15:0] scale_step(logic [7:0] src, logic [7:0] dst);
    logic [31:0] q;
    if (dst == 0) return 16'd0;
    q = ({24'd0, src} << 7) / dst;
    return q[15:0];
  endfunction

  function automatic logic [3:0] src_nibble(logic [31:0] base, logic [31:0] pos);
    logic [31:0] idx;
    logic [7:0]  b;
    logic [3:0]  n;
    idx = base + (pos >> 7);
    b = img_store[(idx >> 1) % STORE_BYTES];
    n = idx[0] ? b[3:0] : b[7:4];
    if (m_remap_en) n = m_remap[4*n +: 4];
    return n;
  endfunction

  // returns 1 and the expected beat when the fetch lands inside the image
  function automatic bit scale_fetch(logic [6:0] row, logic [5:0] col,
                                     output scaled_byte_t r);
    logic [31:0] srow, sstride, dstride, hp, base;
    r = '0;
    if (row >= m_dh || col >= ((32'(m_dw) + 1) >> 1)) return 0;
    sstride = (32'(m_sw) + 1) & 32'hffff_fffe;
    dstride = (32'(m_dw) + 1) & 32'hffff_fffe;
    srow = ((32'(m_vstep) >> 1) + row * 32'(m_vstep)) >> 7;
    hp = (32'(m_hstep) >> 1) + 2 * col * 32'(m_hstep);
    base = srow * sstride;
    r.pair = {src_nibble(base, hp), src_nibble(base, hp + 32'(m_hstep))};
    r.addr = 13'(row * (dstride >> 1) + col);
    return 1;
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SRC_W:     m_sw = val[7:0];
      REG_SRC_H:     m_sh = val[7:0];
      REG_DST_W:     m_dw = val[7:0];
      REG_DST_H:     m_dh = val[7:0];
      REG_REMAP_EN:  m_remap_en = val[0];
      REG_REMAP_TBL: m_remap = val;
      default: ;
    endcase
    m_hstep = scale_step(m_sw, m_dw);
    m_vstep = scale_step(m_sh, m_dh);
  endtask

  task automatic set_sizes(int sw, int sh, int dw, int dh);
    write_reg(REG_SRC_W, 64'(sw));
    write_reg(REG_SRC_H, 64'(sh));
    write_reg(REG_DST_W, 64'(dw));
    write_reg(REG_DST_H, 64'(dh));
  endtask

  // one beat; valid stays high across back-to-back beats
  task automatic send_beat(logic mode, logic [12:0] a, logic [7:0] d,
                           logic [6:0] row, logic [5:0] col);
    scaled_byte_t r;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_load_address <= a;
    in_load_data <= d;
    in_dest_row <= row;
    in_dest_column <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mode == MODE_LOAD) begin
      img_store[a] = d;
      load_beats++;
    end else begin
      fetch_beats++;
      if (scale_fetch(row, col, r)) pending_bytes.push_back(r);
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // loads every byte that any fetch of the current sizes can reach; the
  // second pixel of an odd-width row can run up to one row past the image
  task automatic load_image();
    int n;
    n = int'((32'(m_sw) + 1) & 32'hffff_fffe) / 2 * (int'(m_sh) + 1);
    for (int i = 0; i < n && i < STORE_BYTES; i++)
      send_beat(MODE_LOAD, 13'(i), 8'($urandom), '0, '0);
    end_burst();
  endtask

  task automatic fetch_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0)
        send_beat(MODE_FETCH, 13'($urandom), 8'($urandom),
                  7'($urandom), 6'($urandom));
      else
        send_beat(MODE_FETCH, 13'($urandom), 8'($urandom),
                  7'($urandom_range(m_dh == 0 ? 0 : m_dh - 1)),
                  6'($urandom_range(m_dw / 2 == 0 ? 0 : (m_dw + 1) / 2 - 1)));
    end
    end_burst();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      scaled_byte_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat pair=%h addr=%h",
                                       out_pixel_pair, out_dest_address);
      end else begin
        want = pending_bytes.pop_front();
        checked++;
        if (want.pair !== out_pixel_pair || want.addr !== out_dest_address) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp pair=%h addr=%h got pair=%h addr=%h",
                     want.pair, want.addr, out_pixel_pair, out_dest_address);
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
      end
      out_stall <= (idle_pct != 0 && $urandom_range(99) < idle_pct);
    end
  end

  task automatic test_directed();
    set_sizes(8, 4, 16, 8);
    load_image();
    // full-range load address, then extreme fetches and out-of-image ones
    send_beat(MODE_LOAD, 13'h1fff, 8'hff, 7'h7f, 6'h3f);
    send_beat(MODE_FETCH, '0, '0, 7'd0, 6'd0);
    send_beat(MODE_FETCH, '0, '0, 7'd7, 6'd7);
    send_beat(MODE_FETCH, '0, '0, 7'd8, 6'd0);
    send_beat(MODE_FETCH, '0, '0, 7'd0, 6'd8);
    send_beat(MODE_FETCH, '0, '0, 7'h7f, 6'h3f);
    end_burst();
    write_reg(REG_REMAP_TBL, 64'h0123_4567_89ab_cdef);
    write_reg(REG_REMAP_EN, 64'd1);
    for (int i = 0; i < 8; i++) send_beat(MODE_FETCH, '0, '0, 7'(i), 6'(i));
    end_burst();
    write_reg(REG_REMAP_EN, 64'd0);
    // zero destination width: nothing is inside
    write_reg(REG_DST_W, 64'd0);
    send_beat(MODE_FETCH, '0, '0, 7'd0, 6'd0);
    end_burst();
    set_sizes(1, 1, 1, 1);
    send_beat(MODE_FETCH, '0, '0, 7'd0, 6'd0);
    end_burst();
  endtask

  task automatic test_random_scaling();
    // wide and short source at full destination size, no idling
    set_sizes(128, 2, 128, 128);
    idle_pct = 0;
    load_image();
    fetch_random(60);
    idle_pct = 18;
    for (int ph = 0; ph < 4; ph++) begin
      set_sizes($urandom_range(1, 20), $urandom_range(1, 20),
                $urandom_range(1, 128), $urandom_range(1, 128));
      write_reg(REG_REMAP_EN, 64'($urandom_range(1)));
      write_reg(REG_REMAP_TBL, {$urandom, $urandom});
      load_image();
      fetch_random(60);
    end
    // largest horizontal step, reusing the bytes loaded above
    set_sizes(128, 2, 1, 1);
    fetch_random(10);
    // largest vertical step on a tall narrow source
    set_sizes(2, 128, 5, 1);
    load_image();
    fetch_random(20);
    set_sizes(1, 1, 128, 128);
    load_image();
    fetch_random(60);
  endtask

  task automatic test_backpressure();
    set_sizes(8, 8, 64, 64);
    load_image();
    idle_pct = 0;
    hold_off = 1'b1;
    fetch_random(60);
    idle_pct = 18;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_mode = MODE_LOAD; in_load_address = '0;
    in_load_data = '0; in_dest_row = '0; in_dest_column = '0;
    cfg_valid = 1'b0; cfg_index = REG_SRC_W; cfg_data = '0;
    idle_pct = 18; hold_off = 1'b0;
    mismatches = 0; checked = 0; load_beats = 0; fetch_beats = 0;
    for (int i = 0; i < STORE_BYTES; i++) img_store[i] = '0;
    m_sw = 128; m_sh = 128; m_dw = 128; m_dh = 128;
    m_remap_en = 0; m_remap = '0;
    m_hstep = scale_step(m_sw, m_dw);
    m_vstep = scale_step(m_sh, m_dh);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_scaling();
    test_backpressure();
    wait_drained();
    $display("covered %0d loads and %0d fetches (%0d results checked)",
             load_beats, fetch_beats, checked);
    $display("over wide, tall, shrinking, stretching, remapped and stalled runs");
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("PASS nibble_image_stretch");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, pending_bytes.size());
      $display("FAIL nibble_image_stretch");
    end
    $finish;
  end
endmodule
